// ===== rtl/tpq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpq_pkg: shared types and constants for the two-class priority queue
// Holds command and status codes, port widths, parameter defaults and the
// command bundle passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package tpq_pkg;

    // Parameter defaults
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int TAG_WIDTH_DEF   = 16;

    // Fixed port widths
    localparam int IO_TAG_W   = 16;
    localparam int CAP_W      = 7;
    localparam int WAITING_W  = 7;
    localparam int DROP_W     = 32;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;

    // Input command codes
    localparam logic CMD_ARRIVAL     = 1'b0;
    localparam logic CMD_SERVICE_END = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_QUEUED      = 3'd0,
        ST_DROPPED     = 3'd1,
        ST_STARTED     = 3'd2,
        ST_FWD_NEXT    = 3'd3,
        ST_FWD_IDLE    = 3'd4,
        ST_ERROR       = 3'd5
    } status_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;   // capture the input transfer
        logic execute;   // apply the held item and load the result register
    } ctrl_cmd_t;

endpackage : tpq_pkg
`default_nettype wire

// ===== rtl/tpq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpq_ctrl: controller of the two-class priority queue
// Two-state sequencer: take one input transfer, then apply it once the
// result register is free. Owns the output valid flag.
// ----------------------------------------------------------------------------
module tpq_ctrl
    import tpq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output ctrl_cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   res_free;

    // Result register may be reloaded when empty or being drained
    assign res_free = !out_valid_reg || out_ready;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (res_free)
                begin
                    cmd.execute    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule : tpq_ctrl
`default_nettype wire

// ===== rtl/tpq_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tpq_datapath: FIFOs, server state and result register
// Two circular tag stores with head/tail pointers and counts, the server
// registers, the saturating drop counter and the capacity register.
// ----------------------------------------------------------------------------
module tpq_datapath
    import tpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TAG_WIDTH   = TAG_WIDTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ctrl_cmd_t            cmd,
    input  wire logic                 cfg_valid,
    input  wire logic [CAP_W-1:0]     cfg_data,
    input  wire logic                 command,
    input  wire logic                 arrival_is_alarm,
    input  wire logic [IO_TAG_W-1:0]  arrival_tag,
    output logic [2:0]                status,
    output logic [IO_TAG_W-1:0]       forwarded_tag,
    output logic                      forwarded_is_alarm,
    output logic [IO_TAG_W-1:0]       started_tag,
    output logic                      started_is_alarm,
    output logic [WAITING_W-1:0]      alarm_waiting,
    output logic [WAITING_W-1:0]      telemetry_waiting,
    output logic                      server_busy,
    output logic [DROP_W-1:0]         drops_total
);

    localparam int ADDR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W  = CNT_W + CAP_W + 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(QUEUE_DEPTH - 1);
    localparam logic [CMP_W-1:0]  DEPTH_CMP = CMP_W'(QUEUE_DEPTH);

    // Tag stores
    logic [TAG_WIDTH-1:0] alarm_mem [QUEUE_DEPTH];
    logic [TAG_WIDTH-1:0] tele_mem  [QUEUE_DEPTH];
    logic [TAG_WIDTH-1:0] alarm_rd_reg;
    logic [TAG_WIDTH-1:0] tele_rd_reg;

    // Held input item
    logic                 cmd_in_reg;
    logic                 is_alarm_in_reg;
    logic [TAG_WIDTH-1:0] tag_in_reg;
    logic [TAG_WIDTH+IO_TAG_W-1:0] tag_in_ext;

    // Queue and server state
    logic [ADDR_W-1:0]    alarm_head_reg, alarm_head_next;
    logic [ADDR_W-1:0]    alarm_tail_reg, alarm_tail_next;
    logic [CNT_W-1:0]     alarm_cnt_reg,  alarm_cnt_next;
    logic [ADDR_W-1:0]    tele_head_reg,  tele_head_next;
    logic [ADDR_W-1:0]    tele_tail_reg,  tele_tail_next;
    logic [CNT_W-1:0]     tele_cnt_reg,   tele_cnt_next;
    logic                 busy_reg,       busy_next;
    logic [TAG_WIDTH-1:0] serv_tag_reg,   serv_tag_next;
    logic                 serv_alarm_reg, serv_alarm_next;
    logic [DROP_W-1:0]    drop_cnt_reg,   drop_cnt_next;
    logic [CAP_W-1:0]     capacity_reg;

    // Step results
    logic                 push_alarm;
    logic                 push_tele;
    status_t              res_status;
    logic [TAG_WIDTH-1:0] res_fwd_tag;
    logic                 res_fwd_alarm;
    logic [TAG_WIDTH-1:0] res_st_tag;
    logic                 res_st_alarm;
    logic [CMP_W-1:0]     limit;
    logic [CMP_W-1:0]     total;

    // Result register
    status_t              status_reg;
    logic [IO_TAG_W-1:0]  fwd_tag_reg;
    logic                 fwd_alarm_reg;
    logic [IO_TAG_W-1:0]  st_tag_reg;
    logic                 st_alarm_reg;
    logic [WAITING_W-1:0] alarm_wait_reg;
    logic [WAITING_W-1:0] tele_wait_reg;
    logic                 busy_out_reg;
    logic [DROP_W-1:0]    drops_out_reg;

    logic [TAG_WIDTH+IO_TAG_W-1:0] fwd_tag_ext;
    logic [TAG_WIDTH+IO_TAG_W-1:0] st_tag_ext;
    logic [CNT_W+WAITING_W-1:0]    alarm_cnt_ext;
    logic [CNT_W+WAITING_W-1:0]    tele_cnt_ext;

    // Fit the port tag to the stored tag width
    assign tag_in_ext = {{TAG_WIDTH{1'b0}}, arrival_tag};

    // Capture the input transfer
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cmd_in_reg      <= command;
            is_alarm_in_reg <= arrival_is_alarm;
            tag_in_reg      <= tag_in_ext[TAG_WIDTH-1:0];
        end
    end

    // Write tails and read heads of both stores
    always_ff @(posedge clk)
    begin
        if (push_alarm)
        begin
            alarm_mem[alarm_tail_reg] <= tag_in_reg;
        end
        if (push_tele)
        begin
            tele_mem[tele_tail_reg] <= tag_in_reg;
        end
        alarm_rd_reg <= alarm_mem[alarm_head_reg];
        tele_rd_reg  <= tele_mem[tele_head_reg];
    end

    // Effective capacity and current fill
    assign limit = (CMP_W'(capacity_reg) < DEPTH_CMP) ? CMP_W'(capacity_reg) : DEPTH_CMP;
    assign total = CMP_W'(alarm_cnt_reg) + CMP_W'(tele_cnt_reg);

    // Apply one item
    always_comb
    begin
        alarm_head_next = alarm_head_reg;
        alarm_tail_next = alarm_tail_reg;
        alarm_cnt_next  = alarm_cnt_reg;
        tele_head_next  = tele_head_reg;
        tele_tail_next  = tele_tail_reg;
        tele_cnt_next   = tele_cnt_reg;
        busy_next       = busy_reg;
        serv_tag_next   = serv_tag_reg;
        serv_alarm_next = serv_alarm_reg;
        drop_cnt_next   = drop_cnt_reg;
        push_alarm      = 1'b0;
        push_tele       = 1'b0;
        res_status      = ST_ERROR;
        res_fwd_tag     = '0;
        res_fwd_alarm   = 1'b0;
        res_st_tag      = '0;
        res_st_alarm    = 1'b0;
        if (cmd.execute)
        begin
            if (cmd_in_reg == CMD_ARRIVAL)
            begin
                priority if (!busy_reg)
                begin
                    busy_next       = 1'b1;
                    serv_tag_next   = tag_in_reg;
                    serv_alarm_next = is_alarm_in_reg;
                    res_st_tag      = tag_in_reg;
                    res_st_alarm    = is_alarm_in_reg;
                    res_status      = ST_STARTED;
                end
                else if (total < limit)
                begin
                    if (is_alarm_in_reg)
                    begin
                        push_alarm      = 1'b1;
                        alarm_cnt_next  = alarm_cnt_reg + 1'b1;
                        alarm_tail_next = (alarm_tail_reg == LAST_ADDR) ? '0
                                        : alarm_tail_reg + 1'b1;
                    end
                    else
                    begin
                        push_tele      = 1'b1;
                        tele_cnt_next  = tele_cnt_reg + 1'b1;
                        tele_tail_next = (tele_tail_reg == LAST_ADDR) ? '0
                                       : tele_tail_reg + 1'b1;
                    end
                    res_status = ST_QUEUED;
                end
                else
                begin
                    if (drop_cnt_reg != '1)
                    begin
                        drop_cnt_next = drop_cnt_reg + 1'b1;
                    end
                    res_status = ST_DROPPED;
                end
            end
            else if (busy_reg)
            begin
                // Forward the packet in service, then start the next by class
                res_fwd_tag   = serv_tag_reg;
                res_fwd_alarm = serv_alarm_reg;
                priority if (alarm_cnt_reg != '0)
                begin
                    serv_tag_next   = alarm_rd_reg;
                    serv_alarm_next = 1'b1;
                    alarm_cnt_next  = alarm_cnt_reg - 1'b1;
                    alarm_head_next = (alarm_head_reg == LAST_ADDR) ? '0
                                    : alarm_head_reg + 1'b1;
                    res_st_tag      = alarm_rd_reg;
                    res_st_alarm    = 1'b1;
                    res_status      = ST_FWD_NEXT;
                end
                else if (tele_cnt_reg != '0)
                begin
                    serv_tag_next   = tele_rd_reg;
                    serv_alarm_next = 1'b0;
                    tele_cnt_next   = tele_cnt_reg - 1'b1;
                    tele_head_next  = (tele_head_reg == LAST_ADDR) ? '0
                                    : tele_head_reg + 1'b1;
                    res_st_tag      = tele_rd_reg;
                    res_st_alarm    = 1'b0;
                    res_status      = ST_FWD_NEXT;
                end
                else
                begin
                    busy_next       = 1'b0;
                    serv_tag_next   = '0;
                    serv_alarm_next = 1'b0;
                    res_status      = ST_FWD_IDLE;
                end
            end
        end
    end

    // Hold queue, server and configuration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_head_reg <= '0;
            alarm_tail_reg <= '0;
            alarm_cnt_reg  <= '0;
            tele_head_reg  <= '0;
            tele_tail_reg  <= '0;
            tele_cnt_reg   <= '0;
            busy_reg       <= 1'b0;
            serv_tag_reg   <= '0;
            serv_alarm_reg <= 1'b0;
            drop_cnt_reg   <= '0;
            capacity_reg   <= CAPACITY_RESET;
        end
        else
        begin
            alarm_head_reg <= alarm_head_next;
            alarm_tail_reg <= alarm_tail_next;
            alarm_cnt_reg  <= alarm_cnt_next;
            tele_head_reg  <= tele_head_next;
            tele_tail_reg  <= tele_tail_next;
            tele_cnt_reg   <= tele_cnt_next;
            busy_reg       <= busy_next;
            serv_tag_reg   <= serv_tag_next;
            serv_alarm_reg <= serv_alarm_next;
            drop_cnt_reg   <= drop_cnt_next;
            if (cfg_valid)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    // Fit stored values to port widths
    assign fwd_tag_ext   = {{IO_TAG_W{1'b0}}, res_fwd_tag};
    assign st_tag_ext    = {{IO_TAG_W{1'b0}}, res_st_tag};
    assign alarm_cnt_ext = {{WAITING_W{1'b0}}, alarm_cnt_next};
    assign tele_cnt_ext  = {{WAITING_W{1'b0}}, tele_cnt_next};

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            status_reg     <= res_status;
            fwd_tag_reg    <= fwd_tag_ext[IO_TAG_W-1:0];
            fwd_alarm_reg  <= res_fwd_alarm;
            st_tag_reg     <= st_tag_ext[IO_TAG_W-1:0];
            st_alarm_reg   <= res_st_alarm;
            alarm_wait_reg <= alarm_cnt_ext[WAITING_W-1:0];
            tele_wait_reg  <= tele_cnt_ext[WAITING_W-1:0];
            busy_out_reg   <= busy_next;
            drops_out_reg  <= drop_cnt_next;
        end
    end

    assign status             = status_reg;
    assign forwarded_tag      = fwd_tag_reg;
    assign forwarded_is_alarm = fwd_alarm_reg;
    assign started_tag        = st_tag_reg;
    assign started_is_alarm   = st_alarm_reg;
    assign alarm_waiting      = alarm_wait_reg;
    assign telemetry_waiting  = tele_wait_reg;
    assign server_busy        = busy_out_reg;
    assign drops_total        = drops_out_reg;

endmodule : tpq_datapath
`default_nettype wire

// ===== rtl/two_class_priority_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// two_class_priority_queue: strict-priority queue, two classes, one server
// Each input item is first held in the input registers, then applied and
// loaded into the result register once that register is free; the controller
// takes no new item until the held one has been applied. Store reads are registered.
// A new item is taken while the previous result still waits to be taken.
// Reset (rst_n, asynchronous, active low): queues empty, server idle, drop
// count zero, capacity 64; no clearing pass is needed.
// ----------------------------------------------------------------------------
module two_class_priority_queue
    import tpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TAG_WIDTH   = TAG_WIDTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 command,
    input  wire logic                 arrival_is_alarm,
    input  wire logic [IO_TAG_W-1:0]  arrival_tag,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [2:0]                status,
    output logic [IO_TAG_W-1:0]       forwarded_tag,
    output logic                      forwarded_is_alarm,
    output logic [IO_TAG_W-1:0]       started_tag,
    output logic                      started_is_alarm,
    output logic [WAITING_W-1:0]      alarm_waiting,
    output logic [WAITING_W-1:0]      telemetry_waiting,
    output logic                      server_busy,
    output logic [DROP_W-1:0]         drops_total,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CAP_W-1:0]     cfg_data
);

    ctrl_cmd_t cmd;

    // Capacity writes complete at once
    assign cfg_ready = 1'b1;

    tpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    tpq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_WIDTH   (TAG_WIDTH)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .cfg_valid          (cfg_valid),
        .cfg_data           (cfg_data),
        .command            (command),
        .arrival_is_alarm   (arrival_is_alarm),
        .arrival_tag        (arrival_tag),
        .status             (status),
        .forwarded_tag      (forwarded_tag),
        .forwarded_is_alarm (forwarded_is_alarm),
        .started_tag        (started_tag),
        .started_is_alarm   (started_is_alarm),
        .alarm_waiting      (alarm_waiting),
        .telemetry_waiting  (telemetry_waiting),
        .server_busy        (server_busy),
        .drops_total        (drops_total)
    );

endmodule : two_class_priority_queue
`default_nettype wire
